/* hdl/lfs_pkg.sv */
package lfs_pkg;

  localparam int unsigned SENSOR_BITS = 16;
  localparam logic [15:0] PATTERN_MASK = 16'((17'd1 << SENSOR_BITS) - 17'd1);
  localparam logic [15:0] LEFT_EDGE_PATTERN  = 16'd32768;
  localparam logic [15:0] RIGHT_EDGE_PATTERN = 16'd1;

  localparam logic [9:0]  DERIV_SCALE = 10'd1000;
  localparam int unsigned DIVIDEND_W  = 26;
  localparam int unsigned DIV_CNT_W   = $clog2(DIVIDEND_W);
  localparam int unsigned ACC_W       = 33;

  localparam logic CMD_DRIVE = 1'b0;
  localparam logic CMD_BRAKE = 1'b1;

  typedef enum logic [2:0] {
    CFG_GAIN_P       = 3'd0,
    CFG_GAIN_D       = 3'd1,
    CFG_BASE_SPEED   = 3'd2,
    CFG_MAX_SPEED    = 3'd3,
    CFG_MIN_SPEED    = 3'd4,
    CFG_CORNER_SPEED = 3'd5,
    CFG_CENTRE_LOW   = 3'd6,
    CFG_CENTRE_HIGH  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CORNER_NONE  = 2'd0,
    CORNER_LEFT  = 2'd1,
    CORNER_RIGHT = 2'd2
  } corner_e;

  typedef enum logic [1:0] {
    EMIT_MIN   = 2'd0,
    EMIT_BRAKE = 2'd1,
    EMIT_SPIN  = 2'd2,
    EMIT_PD    = 2'd3
  } emit_e;

  typedef struct packed {
    logic  load_in;
    logic  upd_time;
    logic  clear_corner;
    logic  set_corner;
    logic  mult;
    logic  div_step;
    logic  prod_p;
    logic  prod_d;
    logic  sum;
    logic  emit;
    emit_e emit_kind;
    logic  emit_last;
  } cmd_t;

  typedef struct packed {
    logic corner;
    logic outside;
    logic pat_zero;
    logic pat_edge;
    logic elapsed_zero;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

/* hdl/lfs_if.sv */
interface lfs_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        sensor_pattern;
  logic signed [15:0] position_error;
  logic [31:0]        time_ms;

  modport source (output valid, sensor_pattern, position_error, time_ms, input ready);
  modport sink   (input valid, sensor_pattern, position_error, time_ms, output ready);
endinterface

interface lfs_out_if;
  logic               valid;
  logic               ready;
  logic               command_kind;
  logic signed [15:0] drive_a;
  logic signed [15:0] drive_b;
  logic               last_of_run;

  modport source (output valid, command_kind, drive_a, drive_b, last_of_run, input ready);
  modport sink   (input valid, command_kind, drive_a, drive_b, last_of_run, output ready);
endinterface

interface lfs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/lfs_ctrl.sv */
module lfs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lfs_pkg::sts_t sts_i,
  output lfs_pkg::cmd_t cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DECODE = 9'b000000010,
    ST_MULT   = 9'b000000100,
    ST_DIV    = 9'b000001000,
    ST_PROD_P = 9'b000010000,
    ST_PROD_D = 9'b000100000,
    ST_SUM    = 9'b001000000,
    ST_EMIT   = 9'b010000000,
    ST_SPIN   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.corner) begin
          if (!sts_i.outside) begin
            cmd_o.clear_corner = 1'b1;
            state_d            = ST_IDLE;
          end else if (sts_i.out_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_kind = lfs_pkg::EMIT_SPIN;
            cmd_o.emit_last = 1'b1;
            state_d         = ST_IDLE;
          end
        end else if (sts_i.pat_zero) begin
          if (sts_i.out_free) begin
            cmd_o.upd_time  = 1'b1;
            cmd_o.emit      = 1'b1;
            cmd_o.emit_kind = lfs_pkg::EMIT_MIN;
            cmd_o.emit_last = 1'b1;
            state_d         = ST_IDLE;
          end
        end else if (sts_i.pat_edge) begin
          if (sts_i.out_free) begin
            cmd_o.upd_time   = 1'b1;
            cmd_o.emit       = 1'b1;
            cmd_o.emit_kind  = lfs_pkg::EMIT_BRAKE;
            cmd_o.emit_last  = !sts_i.outside;
            cmd_o.set_corner = sts_i.outside;
            state_d          = sts_i.outside ? ST_SPIN : ST_IDLE;
          end
        end else begin
          cmd_o.upd_time = 1'b1;
          state_d        = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = sts_i.elapsed_zero ? ST_PROD_P : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_PROD_P;
        end
      end
      ST_PROD_P: begin
        cmd_o.prod_p = 1'b1;
        state_d      = ST_PROD_D;
      end
      ST_PROD_D: begin
        cmd_o.prod_d = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = lfs_pkg::EMIT_PD;
          cmd_o.emit_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_SPIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = lfs_pkg::EMIT_SPIN;
          cmd_o.emit_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/lfs_dp.sv */
module lfs_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [15:0]        sensor_pattern_i,
  input  logic signed [15:0] position_error_i,
  input  logic [31:0]        time_ms_i,
  input  lfs_pkg::cmd_t      cmd_i,
  output lfs_pkg::sts_t      sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               command_kind_o,
  output logic signed [15:0] drive_a_o,
  output logic signed [15:0] drive_b_o,
  output logic               last_of_run_o
);

  localparam int unsigned DW = lfs_pkg::DIVIDEND_W;
  localparam int unsigned AW = lfs_pkg::ACC_W;

  logic signed [15:0] gain_p_q, gain_d_q, min_q;
  logic [14:0]        base_q, max_q, corner_spd_q;
  logic [15:0]        lo_q, hi_q;

  logic [15:0]        pat_q;
  logic signed [15:0] err_q;
  logic [31:0]        time_q;

  logic [31:0]        prev_time_q, elapsed_q;
  logic signed [15:0] prev_err_q;
  lfs_pkg::corner_e   corner_q;

  logic                           neg_q;
  logic [DW-1:0]                  quo_q;
  logic [32:0]                    rem_q;
  logic [lfs_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic signed [15:0]             deriv_q;
  logic signed [31:0]             prod_q;
  logic signed [AW-1:0]           acc_q;

  logic                           out_valid_q, kind_q, last_q;
  logic signed [15:0]             drv_a_q, drv_b_q;

  logic signed [16:0] diff_w;
  logic [16:0]        diff_mag_w;
  logic [DW-1:0]      dividend_w;
  logic [32:0]        rem_shift_w;
  logic               rem_ge_w;
  logic signed [15:0] deriv_w;
  logic signed [31:0] prod_p_w, prod_d_w;
  logic signed [24:0] corr_w;
  logic signed [25:0] base_w, sum_a_w, sum_b_w;
  logic signed [15:0] min_sat_w, spin_w;
  logic signed [15:0] drv_a_d, drv_b_d;
  logic               kind_d;

  function automatic logic signed [15:0] clamp_drive(logic signed [25:0] v,
                                                     logic [14:0] lim);
    logic signed [25:0] lim_w;
    lim_w = $signed({11'd0, lim});
    if (v > lim_w) begin
      return 16'(lim_w);
    end else if (v < -lim_w) begin
      return 16'(-lim_w);
    end
    return 16'(v);
  endfunction

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q     <= 16'sd256;
      gain_d_q     <= '0;
      base_q       <= '0;
      max_q        <= 15'h7fff;
      min_q        <= '0;
      corner_spd_q <= '0;
      lo_q         <= '0;
      hi_q         <= 16'hffff;
    end else if (cfg_valid_i) begin
      unique case (lfs_pkg::cfg_idx_e'(cfg_index_i))
        lfs_pkg::CFG_GAIN_P:       gain_p_q     <= cfg_data_i;
        lfs_pkg::CFG_GAIN_D:       gain_d_q     <= cfg_data_i;
        lfs_pkg::CFG_BASE_SPEED:   base_q       <= cfg_data_i[14:0];
        lfs_pkg::CFG_MAX_SPEED:    max_q        <= cfg_data_i[14:0];
        lfs_pkg::CFG_MIN_SPEED:    min_q        <= cfg_data_i;
        lfs_pkg::CFG_CORNER_SPEED: corner_spd_q <= cfg_data_i[14:0];
        lfs_pkg::CFG_CENTRE_LOW:   lo_q         <= cfg_data_i;
        lfs_pkg::CFG_CENTRE_HIGH:  hi_q         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sample word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      pat_q  <= sensor_pattern_i & lfs_pkg::PATTERN_MASK;
      err_q  <= position_error_i;
      time_q <= time_ms_i;
    end
  end

  // persistent state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q <= '0;
      prev_err_q  <= '0;
      corner_q    <= lfs_pkg::CORNER_NONE;
    end else begin
      if (cmd_i.upd_time) begin
        prev_time_q <= time_q;
      end
      if (cmd_i.mult) begin
        prev_err_q <= err_q;
      end
      if (cmd_i.clear_corner) begin
        corner_q <= lfs_pkg::CORNER_NONE;
      end else if (cmd_i.set_corner) begin
        corner_q <= (pat_q == lfs_pkg::LEFT_EDGE_PATTERN) ? lfs_pkg::CORNER_LEFT
                                                          : lfs_pkg::CORNER_RIGHT;
      end
    end
  end

  // derivative: |de| * 1000 / elapsed, restoring division one bit a cycle
  assign diff_w      = {err_q[15], err_q} - {prev_err_q[15], prev_err_q};
  assign diff_mag_w  = diff_w[16] ? 17'(-diff_w) : 17'(diff_w);
  assign dividend_w  = DW'(27'(diff_mag_w) * 27'(lfs_pkg::DERIV_SCALE));
  assign rem_shift_w = {rem_q[31:0], quo_q[DW-1]};
  assign rem_ge_w    = rem_shift_w >= {1'b0, elapsed_q};

  always_comb begin
    if (elapsed_q == '0) begin
      deriv_w = 16'sh7fff;
    end else if (!neg_q) begin
      deriv_w = (quo_q > DW'(32767)) ? 16'sh7fff : $signed(quo_q[15:0]);
    end else begin
      deriv_w = (quo_q > DW'(32768)) ? 16'sh8000 : $signed(~quo_q[15:0] + 16'd1);
    end
  end

  assign prod_p_w = gain_p_q * err_q;
  assign prod_d_w = gain_d_q * deriv_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_time) begin
      elapsed_q <= time_q - prev_time_q;
    end
    if (cmd_i.mult) begin
      neg_q <= diff_w[16];
      quo_q <= dividend_w;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge_w ? rem_shift_w - {1'b0, elapsed_q} : rem_shift_w;
      quo_q <= {quo_q[DW-2:0], rem_ge_w};
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.prod_p) begin
      deriv_q <= deriv_w;
      acc_q   <= AW'(prod_p_w);
    end else if (cmd_i.sum) begin
      acc_q <= acc_q + AW'(prod_q);
    end
    if (cmd_i.prod_d) begin
      prod_q <= prod_d_w;
    end
  end

  // result word
  assign corr_w    = acc_q[AW-1:8];
  assign base_w    = $signed({11'd0, base_q});
  assign sum_a_w   = base_w - {corr_w[24], corr_w};
  assign sum_b_w   = base_w + {corr_w[24], corr_w};
  assign min_sat_w = (min_q == 16'sh8000) ? 16'sh8001 : min_q;
  assign spin_w    = $signed({1'b0, corner_spd_q});

  always_comb begin
    kind_d  = lfs_pkg::CMD_DRIVE;
    drv_a_d = '0;
    drv_b_d = '0;
    case (cmd_i.emit_kind)
      lfs_pkg::EMIT_MIN: begin
        drv_a_d = min_sat_w;
        drv_b_d = min_sat_w;
      end
      lfs_pkg::EMIT_BRAKE: begin
        kind_d = lfs_pkg::CMD_BRAKE;
      end
      lfs_pkg::EMIT_SPIN: begin
        drv_a_d = (corner_q == lfs_pkg::CORNER_LEFT) ? spin_w : -spin_w;
        drv_b_d = -drv_a_d;
      end
      lfs_pkg::EMIT_PD: begin
        drv_a_d = clamp_drive(sum_a_w, max_q);
        drv_b_d = clamp_drive(sum_b_w, max_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q  <= kind_d;
      drv_a_q <= drv_a_d;
      drv_b_q <= drv_b_d;
      last_q  <= cmd_i.emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign command_kind_o = kind_q;
  assign drive_a_o      = drv_a_q;
  assign drive_b_o      = drv_b_q;
  assign last_of_run_o  = last_q;

  assign sts_o.corner       = (corner_q == lfs_pkg::CORNER_LEFT) ||
                              (corner_q == lfs_pkg::CORNER_RIGHT);
  assign sts_o.outside      = (pat_q < lo_q) || (pat_q > hi_q);
  assign sts_o.pat_zero     = (pat_q == '0);
  assign sts_o.pat_edge     = (pat_q == lfs_pkg::LEFT_EDGE_PATTERN) ||
                              (pat_q == lfs_pkg::RIGHT_EDGE_PATTERN);
  assign sts_o.elapsed_zero = (elapsed_q == '0);
  assign sts_o.div_last     = (cnt_q == lfs_pkg::DIV_CNT_W'(DW - 1));
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

endmodule

/* hdl/line_follower_pd_steering_top.sv */
// Order: a PD word is decoded, sent through the 26-bit restoring divider (skipped if no
//   time elapsed), the P and D products and the sum; empty, edge and corner words are
//   answered from decode, a spin word after its brake word. Throughput: one word at a
//   time, taken the cycle after the last result is registered; a held result does not
//   block the next accept. Reset: rst_ni asynchronous active low; config registers
//   go to their defaults, previous time and error clear, corner mode off.
module line_follower_pd_steering_top (
  input logic       clk_i,
  input logic       rst_ni,
  lfs_in_if.sink    in_i,
  lfs_out_if.source out_o,
  lfs_cfg_if.sink   cfg_i
);

  lfs_pkg::cmd_t cmd;
  lfs_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  lfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lfs_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_index_i      (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .sensor_pattern_i (in_i.sensor_pattern),
    .position_error_i (in_i.position_error),
    .time_ms_i        (in_i.time_ms),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .command_kind_o   (out_o.command_kind),
    .drive_a_o        (out_o.drive_a),
    .drive_b_o        (out_o.drive_b),
    .last_of_run_o    (out_o.last_of_run)
  );

`ifndef SYNTHESIS
  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("result word overwritten");

  a_corner_after_brake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.set_corner |-> (cmd.emit && !cmd.emit_last &&
                        cmd.emit_kind == lfs_pkg::EMIT_BRAKE))
    else $error("corner entered without brake word");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("second word taken while busy");
`endif

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 3000;
  localparam int PHASES        = 14;
  localparam int PHASE_WORDS   = 50;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] drive_a;
    logic signed [15:0] drive_b;
    logic               last;
  } steer_cmd_t;

  typedef struct packed {
    logic [15:0]        pattern;
    logic signed [15:0] error;
    logic [31:0]        stamp;
  } line_sample_t;

  typedef enum bit [1:0] {STEP_SAMPLE, STEP_KNOWN, STEP_WRITE} step_e;

  typedef struct {
    step_e             op;
    lfs_pkg::cfg_idx_e idx;
    logic [15:0]       data;
    line_sample_t      smp;
    steer_cmd_t        known;
  } step_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  lfs_in_if  in_if ();
  lfs_out_if out_if ();
  lfs_cfg_if cfg_if ();

  line_follower_pd_steering_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // register shadow and controller state
  logic signed [15:0] gain_p_q, gain_d_q, min_speed_q;
  logic [14:0]        base_speed_q, max_speed_q, corner_speed_q;
  logic [15:0]        centre_low_q, centre_high_q;
  logic [31:0]        last_stamp;
  logic signed [15:0] prev_error;
  lfs_pkg::corner_e   turning;

  steer_cmd_t drive_cmds_due [$];
  int         mismatches   = 0;
  bit         lazy_sides   = 1'b1;
  bit         hold_request = 1'b0;
  logic [31:0] clock_ms    = '0;

  step_t directed_steps [] = '{
    '{STEP_KNOWN,  lfs_pkg::CFG_GAIN_P, 16'h0, '{16'h0000, 0, 0},
      '{lfs_pkg::CMD_DRIVE, 0, 0, 1'b1}},
    '{STEP_KNOWN,  lfs_pkg::CFG_GAIN_P, 16'h0, '{16'h8000, 0, 1},
      '{lfs_pkg::CMD_BRAKE, 0, 0, 1'b1}},
    '{STEP_KNOWN,  lfs_pkg::CFG_GAIN_P, 16'h0, '{16'h0001, 0, 2},
      '{lfs_pkg::CMD_BRAKE, 0, 0, 1'b1}},
    '{STEP_KNOWN,  lfs_pkg::CFG_GAIN_P, 16'h0, '{16'h0180, 100, 12},
      '{lfs_pkg::CMD_DRIVE, -100, 100, 1'b1}},
    '{STEP_KNOWN,  lfs_pkg::CFG_GAIN_P, 16'h0, '{16'hFFFF, -32768, 12},
      '{lfs_pkg::CMD_DRIVE, 32767, -32767, 1'b1}},
    '{STEP_KNOWN,  lfs_pkg::CFG_GAIN_P, 16'h0, '{16'h7FFE, 32767, 20},
      '{lfs_pkg::CMD_DRIVE, -32767, 32767, 1'b1}},
    '{STEP_WRITE,  lfs_pkg::CFG_GAIN_P,       16'hFF80, '0, '0},
    '{STEP_WRITE,  lfs_pkg::CFG_GAIN_D,       16'h0100, '0, '0},
    '{STEP_WRITE,  lfs_pkg::CFG_BASE_SPEED,   16'd1000, '0, '0},
    '{STEP_WRITE,  lfs_pkg::CFG_MAX_SPEED,    16'd2000, '0, '0},
    '{STEP_WRITE,  lfs_pkg::CFG_MIN_SPEED,    16'h8000, '0, '0},
    '{STEP_WRITE,  lfs_pkg::CFG_CORNER_SPEED, 16'd500,  '0, '0},
    '{STEP_WRITE,  lfs_pkg::CFG_CENTRE_LOW,   16'h0010, '0, '0},
    '{STEP_WRITE,  lfs_pkg::CFG_CENTRE_HIGH,  16'h0FF0, '0, '0},
    '{STEP_KNOWN,  lfs_pkg::CFG_GAIN_P, 16'h0, '{16'h0000, 0, 30},
      '{lfs_pkg::CMD_DRIVE, -32767, -32767, 1'b1}},
    '{STEP_SAMPLE, lfs_pkg::CFG_GAIN_P, 16'h0, '{16'h0100, 50, 30}, '0},
    '{STEP_SAMPLE, lfs_pkg::CFG_GAIN_P, 16'h0, '{16'h0200, -50, 35}, '0},
    '{STEP_SAMPLE, lfs_pkg::CFG_GAIN_P, 16'h0, '{16'h0300, 20, 32'hFFFF_FFF0}, '0},
    '{STEP_SAMPLE, lfs_pkg::CFG_GAIN_P, 16'h0, '{16'h0040, -20, 8}, '0},
    '{STEP_SAMPLE, lfs_pkg::CFG_GAIN_P, 16'h0, '{16'h8000, 0, 10}, '0},
    '{STEP_SAMPLE, lfs_pkg::CFG_GAIN_P, 16'h0, '{16'h0000, 0, 11}, '0},
    '{STEP_SAMPLE, lfs_pkg::CFG_GAIN_P, 16'h0, '{16'h0001, 0, 12}, '0},
    '{STEP_SAMPLE, lfs_pkg::CFG_GAIN_P, 16'h0, '{16'h0100, 0, 13}, '0},
    '{STEP_SAMPLE, lfs_pkg::CFG_GAIN_P, 16'h0, '{16'h0001, 0, 20}, '0},
    '{STEP_SAMPLE, lfs_pkg::CFG_GAIN_P, 16'h0, '{16'hFFFF, 0, 21}, '0},
    '{STEP_SAMPLE, lfs_pkg::CFG_GAIN_P, 16'h0, '{16'h0400, 0, 22}, '0},
    '{STEP_SAMPLE, lfs_pkg::CFG_GAIN_P, 16'h0, '{16'h0800, 32767, 23}, '0},
    '{STEP_SAMPLE, lfs_pkg::CFG_GAIN_P, 16'h0, '{16'h0800, -32768, 24}, '0},
    '{STEP_WRITE,  lfs_pkg::CFG_GAIN_P,       16'h8000, '0, '0},
    '{STEP_WRITE,  lfs_pkg::CFG_GAIN_D,       16'h7FFF, '0, '0},
    '{STEP_WRITE,  lfs_pkg::CFG_BASE_SPEED,   16'h7FFF, '0, '0},
    '{STEP_WRITE,  lfs_pkg::CFG_CENTRE_LOW,   16'h0000, '0, '0},
    '{STEP_WRITE,  lfs_pkg::CFG_CENTRE_HIGH,  16'hFFFF, '0, '0},
    '{STEP_SAMPLE, lfs_pkg::CFG_GAIN_P, 16'h0, '{16'h1234, 1, 1000}, '0},
    '{STEP_KNOWN,  lfs_pkg::CFG_GAIN_P, 16'h0, '{16'h8000, 0, 1001},
      '{lfs_pkg::CMD_BRAKE, 0, 0, 1'b1}},
    '{STEP_WRITE,  lfs_pkg::CFG_MIN_SPEED,    16'h7FFF, '0, '0},
    '{STEP_KNOWN,  lfs_pkg::CFG_GAIN_P, 16'h0, '{16'h0000, 0, 1002},
      '{lfs_pkg::CMD_DRIVE, 32767, 32767, 1'b1}}
  };

  function automatic void apply_reg(lfs_pkg::cfg_idx_e idx, logic [15:0] data);
    case (idx)
      lfs_pkg::CFG_GAIN_P:       gain_p_q       = data;
      lfs_pkg::CFG_GAIN_D:       gain_d_q       = data;
      lfs_pkg::CFG_BASE_SPEED:   base_speed_q   = data[14:0];
      lfs_pkg::CFG_MAX_SPEED:    max_speed_q    = data[14:0];
      lfs_pkg::CFG_MIN_SPEED:    min_speed_q    = data;
      lfs_pkg::CFG_CORNER_SPEED: corner_speed_q = data[14:0];
      lfs_pkg::CFG_CENTRE_LOW:   centre_low_q   = data;
      lfs_pkg::CFG_CENTRE_HIGH:  centre_high_q  = data;
      default: ;
    endcase
  endfunction

  function automatic logic signed [15:0] clamp_drive(longint v, longint lim);
    if (v > lim) return 16'(lim);
    if (v < -lim) return 16'(-lim);
    return 16'(v);
  endfunction

  function automatic steer_cmd_t spin_cmd(lfs_pkg::corner_e dir);
    logic signed [15:0] c;
    c = signed'({1'b0, corner_speed_q});
    if (dir == lfs_pkg::CORNER_LEFT) return steer_cmd_t'{lfs_pkg::CMD_DRIVE, c, -c, 1'b1};
    return steer_cmd_t'{lfs_pkg::CMD_DRIVE, -c, c, 1'b1};
  endfunction

  function automatic void predict_steering(line_sample_t s, output steer_cmd_t cmds[$]);
    logic [15:0]        pat;
    logic               outside;
    logic [31:0]        elapsed;
    logic signed [15:0] m;
    longint             deriv, sum, corr;
    cmds = {};
    pat = s.pattern & lfs_pkg::PATTERN_MASK;
    outside = (pat < centre_low_q) || (pat > centre_high_q);
    if (turning == lfs_pkg::CORNER_LEFT || turning == lfs_pkg::CORNER_RIGHT) begin
      if (outside) cmds.push_back(spin_cmd(turning));
      else turning = lfs_pkg::CORNER_NONE;
      return;
    end
    turning = lfs_pkg::CORNER_NONE;
    elapsed = s.stamp - last_stamp;
    last_stamp = s.stamp;
    if (pat == '0) begin
      m = (min_speed_q == 16'sh8000) ? -16'sd32767 : min_speed_q;
      cmds.push_back(steer_cmd_t'{lfs_pkg::CMD_DRIVE, m, m, 1'b1});
      return;
    end
    if (pat == lfs_pkg::LEFT_EDGE_PATTERN || pat == lfs_pkg::RIGHT_EDGE_PATTERN) begin
      if (!outside) begin
        cmds.push_back(steer_cmd_t'{lfs_pkg::CMD_BRAKE, 16'sd0, 16'sd0, 1'b1});
        return;
      end
      cmds.push_back(steer_cmd_t'{lfs_pkg::CMD_BRAKE, 16'sd0, 16'sd0, 1'b0});
      if (pat == lfs_pkg::LEFT_EDGE_PATTERN) turning = lfs_pkg::CORNER_LEFT;
      else turning = lfs_pkg::CORNER_RIGHT;
      cmds.push_back(spin_cmd(turning));
      return;
    end
    if (elapsed == '0) begin
      deriv = 32767;
    end else begin
      deriv = (longint'(s.error) - longint'(prev_error)) * 1000
              / longint'({32'd0, elapsed});
      if (deriv > 32767) deriv = 32767;
      if (deriv < -32768) deriv = -32768;
    end
    prev_error = s.error;
    sum = longint'(gain_p_q) * longint'(s.error) + longint'(gain_d_q) * deriv;
    corr = sum >>> 8;
    cmds.push_back(steer_cmd_t'{lfs_pkg::CMD_DRIVE,
                                clamp_drive(longint'(base_speed_q) - corr, longint'(max_speed_q)),
                                clamp_drive(longint'(base_speed_q) + corr, longint'(max_speed_q)),
                                1'b1});
  endfunction

  task automatic write_reg(input lfs_pkg::cfg_idx_e idx, input logic [15:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic drive_sample(input line_sample_t s, input bit known, input steer_cmd_t want);
    steer_cmd_t cmds [$];
    cfg_if.valid = 1'b0;
    while (lazy_sides && $urandom_range(99) < 26) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid          = 1'b1;
    in_if.sensor_pattern = s.pattern;
    in_if.position_error = s.error;
    in_if.time_ms        = s.stamp;
    do @(posedge clk_i); while (!in_if.ready);
    predict_steering(s, cmds);
    if (known) drive_cmds_due.push_back(want);
    else foreach (cmds[i]) drive_cmds_due.push_back(cmds[i]);
    @(negedge clk_i);
  endtask

  // drain, then give a word that yields nothing time to finish
  task automatic settle();
    in_if.valid = 1'b0;
    while (drive_cmds_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3, 4: return 16'($urandom_range(0, 1536) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_speed();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3, 4: return 16'($urandom_range(0, 4000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_min();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h8001;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic retune();
    logic [15:0] lo, hi, t;
    if ($urandom_range(1)) write_reg(lfs_pkg::CFG_GAIN_P, pick_gain());
    if ($urandom_range(1)) write_reg(lfs_pkg::CFG_GAIN_D, pick_gain());
    if ($urandom_range(1)) write_reg(lfs_pkg::CFG_BASE_SPEED, pick_speed());
    if ($urandom_range(1)) write_reg(lfs_pkg::CFG_MAX_SPEED, pick_speed());
    if ($urandom_range(1)) write_reg(lfs_pkg::CFG_CORNER_SPEED, pick_speed());
    if ($urandom_range(1)) write_reg(lfs_pkg::CFG_MIN_SPEED, pick_min());
    if ($urandom_range(1)) begin
      case ($urandom_range(3))
        0: begin
          lo = 16'h0000;
          hi = 16'hFFFF;
        end
        1, 2: begin
          lo = 16'($urandom_range(2, 32));
          hi = 16'($urandom_range(16'h1000, 16'h7FFF));
        end
        default: begin
          lo = 16'($urandom);
          hi = 16'($urandom);
          if (lo > hi) begin
            t  = lo;
            lo = hi;
            hi = t;
          end
        end
      endcase
      write_reg(lfs_pkg::CFG_CENTRE_LOW, lo);
      write_reg(lfs_pkg::CFG_CENTRE_HIGH, hi);
    end
  endtask

  function automatic line_sample_t random_sample();
    line_sample_t s;
    int unsigned  r;
    r = $urandom_range(99);
    if (r < 10) s.pattern = 16'h0000;
    else if (r < 18) s.pattern = lfs_pkg::LEFT_EDGE_PATTERN;
    else if (r < 26) s.pattern = lfs_pkg::RIGHT_EDGE_PATTERN;
    else if (r < 70) s.pattern = 16'($urandom_range(32, 16'h0FFF));
    else s.pattern = 16'($urandom);
    r = $urandom_range(99);
    if (r < 50) s.error = 16'($urandom_range(0, 4000) - 2000);
    else if (r < 60) s.error = 16'sh8000;
    else if (r < 70) s.error = 16'sh7FFF;
    else s.error = 16'($urandom);
    r = $urandom_range(99);
    if (r < 70) clock_ms = clock_ms + $urandom_range(1, 30);
    else if (r < 90 && r >= 80) clock_ms = $urandom;
    else if (r >= 90) clock_ms = clock_ms + $urandom_range(0, 100000);
    s.stamp = clock_ms;
    return s;
  endfunction

  function automatic void check_field(string field, logic signed [16:0] want,
                                      logic signed [16:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    steer_cmd_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (drive_cmds_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, got kind %0b a %0d b %0d last %0b",
                 $time, out_if.command_kind, out_if.drive_a, out_if.drive_b,
                 out_if.last_of_run);
        mismatches++;
      end else begin
        want = drive_cmds_due.pop_front();
        check_field("command_kind", want.kind, out_if.command_kind);
        check_field("drive_a", want.drive_a, out_if.drive_a);
        check_field("drive_b", want.drive_b, out_if.drive_b);
        check_field("last_of_run", want.last, out_if.last_of_run);
      end
    end
  end

  initial begin : result_taker
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_request = 1'b0;
      end
      out_if.ready = !(lazy_sides && $urandom_range(99) < 26);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    in_if.valid          = 1'b0;
    in_if.sensor_pattern = '0;
    in_if.position_error = '0;
    in_if.time_ms        = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = lfs_pkg::CFG_GAIN_P;
    cfg_if.data          = '0;
    gain_p_q       = 16'sd256;
    gain_d_q       = '0;
    base_speed_q   = '0;
    max_speed_q    = 15'h7FFF;
    min_speed_q    = '0;
    corner_speed_q = '0;
    centre_low_q   = '0;
    centre_high_q  = 16'hFFFF;
    last_stamp     = '0;
    prev_error     = '0;
    turning        = lfs_pkg::CORNER_NONE;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].op == STEP_WRITE) begin
        if (i == 0 || directed_steps[i - 1].op != STEP_WRITE) settle();
        write_reg(directed_steps[i].idx, directed_steps[i].data);
      end else begin
        drive_sample(directed_steps[i].smp, directed_steps[i].op == STEP_KNOWN,
                     directed_steps[i].known);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      retune();
      lazy_sides = (phase != 3);
      if (phase == 6) hold_request = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (phase == 9 && n == PHASE_WORDS / 2) begin
          in_if.valid = 1'b0;
          while (drive_cmds_due.size() != 0) @(negedge clk_i);
        end
        drive_sample(random_sample(), 1'b0, '0);
      end
    end

    // empty centre window goes last: once cornering, nothing ends it
    settle();
    write_reg(lfs_pkg::CFG_CENTRE_LOW, 16'hFFFF);
    write_reg(lfs_pkg::CFG_CENTRE_HIGH, 16'h0000);
    drive_sample('{16'h0100, 16'sd300, clock_ms + 32'd5}, 1'b0, '0);
    drive_sample('{16'h0000, 16'sd0, clock_ms + 32'd6}, 1'b0, '0);
    drive_sample('{lfs_pkg::LEFT_EDGE_PATTERN, 16'sd0, clock_ms + 32'd7}, 1'b0, '0);
    repeat (10) drive_sample(random_sample(), 1'b0, '0);

    in_if.valid = 1'b0;
    while (drive_cmds_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/lfs_pkg.sv
hdl/lfs_if.sv
hdl/lfs_ctrl.sv
hdl/lfs_dp.sv
hdl/line_follower_pd_steering_top.sv
verif/testbench.sv
